// ----- design/xcr_pkg.sv -----
// ----------------------------------------------------------------------------
// xcr_pkg
// types, codes and helpers shared by the xmodem checksum receiver modules
// ----------------------------------------------------------------------------
package xcr_pkg;

  localparam int unsigned PAYLOAD_BYTES = 128;
  localparam int unsigned POS_W = $clog2(PAYLOAD_BYTES + 4);
  localparam logic [POS_W-1:0] POS_CSUM = POS_W'(PAYLOAD_BYTES + 3);

  localparam int unsigned MAX_RES = 3;
  localparam int unsigned RES_IDX_W = 2;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] NUM_PAIR_SUM = 8'hff;

  localparam logic [3:0] BAD_STARTS_RESET = 4'd5;
  localparam logic [7:0] FIRST_NUMBER = 8'd1;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_START   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_REPLY   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    END_NONE     = 2'd0,
    END_COMPLETE = 2'd1,
    END_BAD_STARTS = 2'd2,
    END_TIMEOUT  = 2'd3
  } end_code_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    logic        packet_good;
    end_code_t   end_code;
    logic [15:0] packets_ok;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [RES_IDX_W-1:0] count;
    result_t [MAX_RES-1:0] res;
  } bundle_t;

  function automatic result_t make_result(kind_t kind, logic [7:0] value, logic good,
                                          end_code_t code, logic [15:0] pok,
                                          logic last);
    result_t r;
    r.kind        = kind;
    r.value       = value;
    r.packet_good = good;
    r.end_code    = code;
    r.packets_ok  = pok;
    r.last        = last;
    return r;
  endfunction

endpackage

// ----- design/xcr_core.sv -----
// ----------------------------------------------------------------------------
// xcr_core
// input register and protocol state; turns one event into a group of results
// ----------------------------------------------------------------------------
module xcr_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [3:0]       cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [1:0]       in_op,
  input  logic [7:0]       in_byte,
  input  logic             push_ready,
  output logic             push,
  output xcr_pkg::bundle_t push_bundle
);

  logic                      item_valid;
  xcr_pkg::op_t              item_op;
  logic [7:0]                item_byte;
  logic                      take;

  logic [3:0]                max_bad_starts;
  logic                      session_active, session_active_next;
  logic [xcr_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]                expected_number, expected_number_next;
  logic [7:0]                received_number, received_number_next;
  logic                      number_pair_ok, number_pair_ok_next;
  logic [7:0]                running_sum, running_sum_next;
  logic [3:0]                bad_start_count, bad_start_count_next;
  logic [15:0]               accepted_count, accepted_count_next;
  logic                      good;
  xcr_pkg::bundle_t          bundle;

  assign take      = item_valid && push_ready;
  assign in_tready = !item_valid || take;
  assign push      = take && (bundle.count != '0);
  assign push_bundle = bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_tready) begin
      item_valid <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      item_op   <= xcr_pkg::op_t'(in_op);
      item_byte <= in_byte;
    end
  end

  always_comb begin
    session_active_next  = session_active;
    byte_position_next   = byte_position;
    expected_number_next = expected_number;
    received_number_next = received_number;
    number_pair_ok_next  = number_pair_ok;
    running_sum_next     = running_sum;
    bad_start_count_next = bad_start_count;
    accepted_count_next  = accepted_count;
    good                 = (received_number == expected_number) && number_pair_ok &&
                           (running_sum == item_byte);
    bundle               = '0;

    unique case (item_op)
      xcr_pkg::OP_START: begin
        session_active_next  = 1'b1;
        byte_position_next   = '0;
        expected_number_next = xcr_pkg::FIRST_NUMBER;
        received_number_next = '0;
        number_pair_ok_next  = 1'b0;
        running_sum_next     = '0;
        bad_start_count_next = '0;
        accepted_count_next  = '0;
        bundle.count  = 2'd1;
        bundle.res[0] = xcr_pkg::make_result(xcr_pkg::KIND_REPLY, xcr_pkg::CH_NAK, 1'b0,
                                             xcr_pkg::END_NONE, '0, 1'b1);
      end
      xcr_pkg::OP_TIMEOUT: begin
        if (session_active) begin
          session_active_next = 1'b0;
          byte_position_next  = '0;
          bundle.count  = 2'd1;
          bundle.res[0] = xcr_pkg::make_result(xcr_pkg::KIND_END, 8'h00, 1'b0,
                                               xcr_pkg::END_TIMEOUT, accepted_count, 1'b1);
        end
      end
      xcr_pkg::OP_BYTE: begin
        if (session_active) begin
          if (byte_position == '0) begin
            if (item_byte == xcr_pkg::CH_SOH) begin
              byte_position_next = xcr_pkg::POS_W'(1);
              running_sum_next   = '0;
            end else if (item_byte == xcr_pkg::CH_EOT) begin
              session_active_next = 1'b0;
              bundle.count  = 2'd3;
              bundle.res[0] = xcr_pkg::make_result(xcr_pkg::KIND_REPLY, xcr_pkg::CH_ACK,
                                1'b0, xcr_pkg::END_NONE, accepted_count, 1'b0);
              bundle.res[1] = xcr_pkg::make_result(xcr_pkg::KIND_REPLY, xcr_pkg::CH_ACK,
                                1'b0, xcr_pkg::END_NONE, accepted_count, 1'b0);
              bundle.res[2] = xcr_pkg::make_result(xcr_pkg::KIND_END, 8'h00,
                                1'b0, xcr_pkg::END_COMPLETE, accepted_count, 1'b1);
            end else begin
              bad_start_count_next = bad_start_count + 4'd1;
              bundle.count = 2'd1;
              if (bad_start_count_next >= max_bad_starts) begin
                session_active_next = 1'b0;
                bundle.res[0] = xcr_pkg::make_result(xcr_pkg::KIND_END, 8'h00, 1'b0,
                                  xcr_pkg::END_BAD_STARTS, accepted_count, 1'b1);
              end else begin
                bundle.res[0] = xcr_pkg::make_result(xcr_pkg::KIND_REPLY, xcr_pkg::CH_NAK,
                                  1'b0, xcr_pkg::END_NONE, accepted_count, 1'b1);
              end
            end
          end else if (byte_position == xcr_pkg::POS_W'(1)) begin
            received_number_next = item_byte;
            byte_position_next   = xcr_pkg::POS_W'(2);
          end else if (byte_position == xcr_pkg::POS_W'(2)) begin
            number_pair_ok_next = (received_number + item_byte) == xcr_pkg::NUM_PAIR_SUM &&
                                  !(9'(received_number) + 9'(item_byte) > 9'h0ff);
            byte_position_next  = xcr_pkg::POS_W'(3);
          end else if (byte_position < xcr_pkg::POS_CSUM) begin
            running_sum_next   = running_sum + item_byte;
            byte_position_next = byte_position + xcr_pkg::POS_W'(1);
            bundle.count  = 2'd1;
            bundle.res[0] = xcr_pkg::make_result(xcr_pkg::KIND_PAYLOAD, item_byte, 1'b0,
                                                 xcr_pkg::END_NONE, accepted_count, 1'b1);
          end else begin
            byte_position_next = '0;
            bundle.count = 2'd1;
            if (good) begin
              expected_number_next = expected_number + 8'd1;
              accepted_count_next  = accepted_count + 16'd1;
              bundle.res[0] = xcr_pkg::make_result(xcr_pkg::KIND_REPLY, xcr_pkg::CH_ACK,
                                1'b1, xcr_pkg::END_NONE, accepted_count_next, 1'b1);
            end else begin
              bundle.res[0] = xcr_pkg::make_result(xcr_pkg::KIND_REPLY, xcr_pkg::CH_NAK,
                                1'b0, xcr_pkg::END_NONE, accepted_count, 1'b1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bad_starts  <= xcr_pkg::BAD_STARTS_RESET;
      session_active  <= 1'b0;
      byte_position   <= '0;
      expected_number <= xcr_pkg::FIRST_NUMBER;
      received_number <= '0;
      number_pair_ok  <= 1'b0;
      running_sum     <= '0;
      bad_start_count <= '0;
      accepted_count  <= '0;
    end else begin
      if (cfg_we) begin
        max_bad_starts <= cfg_wdata;
      end
      if (take) begin
        session_active  <= session_active_next;
        byte_position   <= byte_position_next;
        expected_number <= expected_number_next;
        received_number <= received_number_next;
        number_pair_ok  <= number_pair_ok_next;
        running_sum     <= running_sum_next;
        bad_start_count <= bad_start_count_next;
        accepted_count  <= accepted_count_next;
      end
    end
  end

endmodule

// ----- design/xcr_out.sv -----
// ----------------------------------------------------------------------------
// xcr_out
// two-deep queue of result groups, drained one result per transaction
// ----------------------------------------------------------------------------
module xcr_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  xcr_pkg::bundle_t    push_bundle,
  output logic                push_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output xcr_pkg::result_t    out_res
);

  xcr_pkg::bundle_t                slot [2];
  logic                            wr_ptr;
  logic                            rd_ptr;
  logic [1:0]                      cnt;
  logic [xcr_pkg::RES_IDX_W-1:0]   idx;
  xcr_pkg::bundle_t                head;
  logic                            pop_res;
  logic                            pop_bundle;

  assign head       = slot[rd_ptr];
  assign out_valid  = cnt != 2'd0;
  assign out_res    = head.res[idx];
  assign push_ready = cnt != 2'd2;
  assign pop_res    = out_valid && out_ready;
  assign pop_bundle = pop_res && (idx == head.count - xcr_pkg::RES_IDX_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
      idx    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_bundle) begin
        rd_ptr <= !rd_ptr;
        idx    <= '0;
      end else if (pop_res) begin
        idx <= idx + xcr_pkg::RES_IDX_W'(1);
      end
      if (push && !pop_bundle) begin
        cnt <= cnt + 2'd1;
      end else if (!push && pop_bundle) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_bundle;
    end
  end

endmodule

// ----- design/xmodem_checksum_receiver.sv -----
// an event is held in the input register, then its results wait in the two-deep output queue
// throughput: one event per cycle with the output ready and at most one result per
//   event; an eot gives three results and holds the output for three transactions
// reset: rst is synchronous; the session is closed, counters cleared, max_bad_starts 5
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver
// receiver side of xmodem with an 8-bit checksum, one event per transaction
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,      // max_bad_starts
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic [1:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // value, packet_good, end_code, packets_ok, zero pad
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast
);

  logic             push;
  logic             push_ready;
  xcr_pkg::bundle_t push_bundle;
  xcr_pkg::result_t out_res;

  xcr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (s_axis_tvalid),
    .in_tready   (s_axis_tready),
    .in_op       (s_axis_tuser),
    .in_byte     (s_axis_tdata),
    .push_ready  (push_ready),
    .push        (push),
    .push_bundle (push_bundle)
  );

  xcr_out u_out (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (push_bundle),
    .push_ready  (push_ready),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_res     (out_res)
  );

  assign m_axis_tdata = {5'd0, out_res.packets_ok, out_res.end_code,
                         out_res.packet_good, out_res.value};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

// ----- tb/sv/xcr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcr_checker
// watches the event and reply streams of the xmodem checksum receiver, keeps
// its own copy of the session and packet state, works out the replies each
// accepted event should cause and compares every reply transaction with the
// oldest one still due
// ----------------------------------------------------------------------------
module xcr_checker
  import xcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic [1:0]  s_axis_tuser,   // op
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // value, packet_good, end_code, packets_ok, zero pad
  input  logic [1:0]  m_axis_tuser,   // kind
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          outstanding
);

  logic        sess_open;
  int unsigned pos;
  logic [7:0]  want_num;
  logic [7:0]  rx_num;
  logic        pair_ok;
  logic [7:0]  csum;
  logic [3:0]  bad_starts;
  logic [15:0] good_packets;
  logic [3:0]  abort_limit;
  int          errs = 0;
  result_t     due_replies[$];

  task automatic add_reply(input kind_t kind, input logic [7:0] value, input logic good,
                           input end_code_t code);
    result_t r;
    r.kind        = kind;
    r.value       = value;
    r.packet_good = good;
    r.end_code    = code;
    r.packets_ok  = good_packets;
    r.last        = 1'b0;
    due_replies.push_back(r);
  endtask

  task automatic advance_receiver(input op_t op, input logic [7:0] b);
    int   base;
    logic good;
    base = due_replies.size();
    case (op)
      OP_START: begin
        sess_open    = 1'b1;
        pos          = 0;
        want_num     = FIRST_NUMBER;
        rx_num       = 8'd0;
        pair_ok      = 1'b0;
        csum         = 8'd0;
        bad_starts   = 4'd0;
        good_packets = 16'd0;
        add_reply(KIND_REPLY, CH_NAK, 1'b0, END_NONE);
      end
      OP_TIMEOUT: begin
        if (sess_open) begin
          sess_open = 1'b0;
          pos       = 0;
          add_reply(KIND_END, 8'd0, 1'b0, END_TIMEOUT);
        end
      end
      OP_BYTE: begin
        if (sess_open) begin
          if (pos == 0) begin
            if (b == CH_SOH) begin
              pos  = 1;
              csum = 8'd0;
            end else if (b == CH_EOT) begin
              add_reply(KIND_REPLY, CH_ACK, 1'b0, END_NONE);
              add_reply(KIND_REPLY, CH_ACK, 1'b0, END_NONE);
              sess_open = 1'b0;
              add_reply(KIND_END, 8'd0, 1'b0, END_COMPLETE);
            end else begin
              bad_starts = bad_starts + 4'd1;
              if (bad_starts >= abort_limit) begin
                sess_open = 1'b0;
                add_reply(KIND_END, 8'd0, 1'b0, END_BAD_STARTS);
              end else begin
                add_reply(KIND_REPLY, CH_NAK, 1'b0, END_NONE);
              end
            end
          end else if (pos == 1) begin
            rx_num = b;
            pos    = 2;
          end else if (pos == 2) begin
            // the pair must add up to 255 exactly, no wrap
            pair_ok = ({1'b0, rx_num} + {1'b0, b}) == 9'h0ff;
            pos     = 3;
          end else if (pos < 3 + PAYLOAD_BYTES) begin
            csum = csum + b;
            pos  = pos + 1;
            add_reply(KIND_PAYLOAD, b, 1'b0, END_NONE);
          end else begin
            good = (rx_num == want_num) && pair_ok && (csum == b);
            pos  = 0;
            if (good) begin
              want_num     = want_num + 8'd1;
              good_packets = good_packets + 16'd1;
              add_reply(KIND_REPLY, CH_ACK, 1'b1, END_NONE);
            end else begin
              add_reply(KIND_REPLY, CH_NAK, 1'b0, END_NONE);
            end
          end
        end
      end
      default: ;
    endcase
    if (due_replies.size() > base)
      due_replies[due_replies.size()-1].last = 1'b1;
  endtask

  task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errs++;
    end
  endtask

  task automatic compare_reply();
    result_t want;
    if (due_replies.size() == 0) begin
      $error("unexpected reply: kind %0d, tdata 0x%0h", m_axis_tuser, m_axis_tdata);
      errs++;
    end else begin
      want = due_replies.pop_front();
      cmp_field("kind", want.kind, m_axis_tuser);
      cmp_field("value", want.value, m_axis_tdata[7:0]);
      cmp_field("packet_good", want.packet_good, m_axis_tdata[8]);
      cmp_field("end_code", want.end_code, m_axis_tdata[10:9]);
      cmp_field("packets_ok", want.packets_ok, m_axis_tdata[26:11]);
      cmp_field("pad", 0, m_axis_tdata[31:27]);
      cmp_field("last", want.last, m_axis_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sess_open    = 1'b0;
      pos          = 0;
      want_num     = FIRST_NUMBER;
      rx_num       = 8'd0;
      pair_ok      = 1'b0;
      csum         = 8'd0;
      bad_starts   = 4'd0;
      good_packets = 16'd0;
      abort_limit  = BAD_STARTS_RESET;
      due_replies.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        compare_reply();
      if (s_axis_tvalid && s_axis_tready)
        advance_receiver(op_t'(s_axis_tuser), s_axis_tdata);
      if (cfg_we)
        abort_limit = cfg_wdata;
    end
    fail_count  <= errs;
    outstanding <= due_replies.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives sessions of xmodem events into the checksum receiver: good, damaged,
// repeated and cut-off packets, bad start bytes, timeouts, restarts and end of
// transfer, under several abort limits and with random gaps on both streams;
// the checker beside the block predicts and compares every reply
// ----------------------------------------------------------------------------
module tb_top;
  import xcr_pkg::*;

  typedef enum int {
    FLAW_NONE,
    FLAW_NUMBER,
    FLAW_COMPLEMENT,
    FLAW_SUM,
    FLAW_REPEAT,
    FLAW_TIMEOUT,
    FLAW_RESTART
  } flaw_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = 4'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // rx_byte
  logic [1:0]  s_axis_tuser = 2'd0;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // value, packet_good, end_code, packets_ok, zero pad
  logic [1:0]  m_axis_tuser;          // kind
  logic        m_axis_tlast;
  int          fail_count;
  int          outstanding;

  int          s_gap_max = 11;
  int          m_gap_max = 11;
  int          sent_items = 0;
  bit          live = 1'b0;
  logic [7:0]  next_num = FIRST_NUMBER;
  int          bad_seen = 0;
  logic [3:0]  limit_now = BAD_STARTS_RESET;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  xmodem_checksum_receiver u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  xcr_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  // reply sink, random stall before each transaction
  initial begin : reply_sink
    int gap;
    forever begin
      gap = $urandom_range(0, m_gap_max);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic send_event(input op_t op, input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, s_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (op == OP_START || (live && op != OP_NONE))
      sent_items++;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    // ignored events give no reply but may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [3:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_now = v;
  endtask

  task automatic start_session();
    send_event(OP_START, 8'($urandom));
    live     = 1'b1;
    next_num = FIRST_NUMBER;
    bad_seen = 0;
  endtask

  task automatic end_by_timeout();
    send_event(OP_TIMEOUT, 8'($urandom));
    live = 1'b0;
  endtask

  task automatic end_by_eot();
    send_event(OP_BYTE, CH_EOT);
    live = 1'b0;
  endtask

  task automatic bad_start(input logic [7:0] b);
    send_event(OP_BYTE, b);
    bad_seen++;
    if (bad_seen >= limit_now)
      live = 1'b0;
  endtask

  function automatic logic [7:0] any_bad_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_SOH || b == CH_EOT);
    return b;
  endfunction

  task automatic send_packet(input flaw_t flaw);
    logic [7:0] num;
    logic [7:0] cpl;
    logic [7:0] sum;
    logic [7:0] pb;
    int         cut;
    int         fill;
    num = next_num;
    if (flaw == FLAW_NUMBER)
      num = next_num + 8'($urandom_range(1, 255));
    else if (flaw == FLAW_REPEAT)
      num = next_num - 8'd1;
    cpl = ~num;
    if (flaw == FLAW_COMPLEMENT)
      cpl = cpl ^ 8'($urandom_range(1, 255));
    cut = PAYLOAD_BYTES + 4;
    if (flaw == FLAW_TIMEOUT || flaw == FLAW_RESTART)
      cut = $urandom_range(1, PAYLOAD_BYTES + 3);
    fill = $urandom_range(0, 3);
    sum  = 8'd0;
    for (int i = 0; i < cut; i++) begin
      if (i == 0) begin
        pb = CH_SOH;
      end else if (i == 1) begin
        pb = num;
      end else if (i == 2) begin
        pb = cpl;
      end else if (i < PAYLOAD_BYTES + 3) begin
        pb  = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hff : 8'($urandom);
        sum = sum + pb;
      end else begin
        pb = sum;
        if (flaw == FLAW_SUM)
          pb = pb ^ 8'($urandom_range(1, 255));
      end
      send_event(OP_BYTE, pb);
    end
    case (flaw)
      FLAW_NONE:    next_num = next_num + 8'd1;
      FLAW_TIMEOUT: end_by_timeout();
      FLAW_RESTART: start_session();
      default: ;
    endcase
  endtask

  task automatic random_session(input int stop_at);
    int r;
    start_session();
    while (live && sent_items < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 60)
        send_packet(FLAW_NONE);
      else if (r < 78)
        send_packet(flaw_t'($urandom_range(1, 6)));
      else if (r < 95)
        bad_start(any_bad_byte());
      else
        start_session();
    end
    if (live) begin
      if ($urandom_range(0, 1))
        end_by_eot();
      else
        end_by_timeout();
    end
    // events outside a session are ignored
    repeat ($urandom_range(0, 2)) begin
      r = $urandom_range(0, 2);
      send_event(r == 0 ? OP_BYTE : r == 1 ? OP_TIMEOUT : OP_NONE, 8'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [3:0] limits[2];
    int         stop_at;
    limits = '{4'd1, 4'($urandom_range(2, 14))};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset limit
    send_event(OP_BYTE, CH_SOH);
    send_event(OP_TIMEOUT, 8'hff);
    send_event(OP_NONE, 8'h00);
    start_session();
    bad_start(8'h00);
    bad_start(8'hff);
    send_packet(FLAW_NONE);
    send_packet(FLAW_SUM);
    send_event(OP_NONE, 8'hff);
    start_session();
    send_packet(FLAW_TIMEOUT);
    start_session();
    send_event(OP_TIMEOUT, 8'h00);
    live = 1'b0;
    start_session();
    end_by_eot();

    set_limit(4'd0);
    start_session();
    bad_start(8'h15);
    set_limit(4'd15);
    start_session();
    while (live)
      bad_start(any_bad_byte());

    sent_items = 0;
    stop_at    = 0;
    foreach (limits[i]) begin
      set_limit(limits[i]);
      stop_at = stop_at + 30;
      while (sent_items < stop_at)
        random_session(stop_at);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
